// ===== sv/clock_page_replacement_defines.svh =====
// Assertion macros shared by the checker of the clock page replacement block.
// Depends on nothing; every use expects a signal named clk in scope, and CPR_ASSERT also rst.
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define CPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CPR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cpr_pkg.sv =====
// Types and codes of the clock page replacement block.
// Used by the frame store, the top level and the checker; depends on nothing.
package cpr_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REF     = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_PRESENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_HAND,
    S_LINK,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic present;
    logic referenced;
  } flag_t;

  typedef struct packed {
    logic flag_we;
    logic next_we;
    logic prev_we;
    logic owner_we;
  } wen_t;

endpackage

// ===== sv/clock_page_replacement.sv =====
// done is registered from the state that answers: idle for an out-of-range frame, replace on
// an empty ring or an unknown kind; check for reference, a present frame or insert into an
// empty ring; link, via check and hand, for other inserts; sweep for replace, past set reference bits.
// One item at a time: start is taken again in the cycle that done shows, and the single read
// port of the frame store sets the sweep at one frame per cycle. Results cannot be stalled.
// After reset, busy stays high while the flag memory is cleared.
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int FRAMES = 64,
  parameter int PROCESS_COUNT = 16,
  localparam int FW = $clog2(FRAMES),
  localparam int PW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1,
  localparam int CW = $clog2(FRAMES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    kind,
  input  logic [PW-1:0] owner_pid,
  input  logic [FW-1:0] frame_index,
  input  logic          ref_on_insert,
  output logic          done,
  output logic [1:0]    status,
  output logic [FW-1:0] victim_frame,
  output logic [PW-1:0] victim_pid
);

  state_t        state, state_next;
  kind_t         kind_in, kind_r;
  logic [FW-1:0] f_r, hand, hand_next, cur, cur_next, behind, behind_next;
  logic [FW-1:0] clr_idx, clr_next;
  logic [PW-1:0] pid_r;
  logic          refi_r;
  logic [CW-1:0] count, count_next;
  logic          accept, f_valid;

  logic          res_fire;
  status_t       res_status;
  logic [FW-1:0] res_frame;
  logic [PW-1:0] res_pid;

  logic [FW-1:0] rd_addr, flag_addr, next_addr, next_data, prev_addr, prev_data;
  wen_t          wen;
  flag_t         flag_data, flag_q;
  logic [FW-1:0] next_q, prev_q;
  logic [PW-1:0] owner_q;

  assign kind_in = kind_t'(kind);
  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign f_valid = ({1'b0, frame_index} < (FW + 1)'(FRAMES));

  cpr_store #(
    .FRAMES        (FRAMES),
    .PROCESS_COUNT (PROCESS_COUNT)
  ) u_store (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .wen        (wen),
    .flag_addr  (flag_addr),
    .flag_data  (flag_data),
    .next_addr  (next_addr),
    .next_data  (next_data),
    .prev_addr  (prev_addr),
    .prev_data  (prev_data),
    .owner_addr (f_r),
    .owner_data (pid_r),
    .flag_q     (flag_q),
    .next_q     (next_q),
    .prev_q     (prev_q),
    .owner_q    (owner_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == FW'(FRAMES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (kind_in)
            KIND_INSERT, KIND_REF: begin
              if (f_valid) begin
                state_next = S_CHECK;
              end
            end
            KIND_REPLACE: begin
              if (count != '0) begin
                state_next = S_SWEEP;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if ((kind_r == KIND_INSERT) && !flag_q.present && (count != '0)) begin
          state_next = S_HAND;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HAND:  state_next = S_LINK;
      S_LINK:  state_next = S_IDLE;
      S_SWEEP: begin
        if (!flag_q.referenced) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr     = cur;
    wen         = '0;
    flag_addr   = f_r;
    flag_data   = '0;
    next_addr   = f_r;
    next_data   = hand;
    prev_addr   = f_r;
    prev_data   = prev_q;
    res_fire    = 1'b0;
    res_status  = STAT_OK;
    res_frame   = '0;
    res_pid     = '0;
    hand_next   = hand;
    count_next  = count;
    cur_next    = cur;
    behind_next = behind;
    clr_next    = clr_idx;
    unique case (state)
      S_CLEAR: begin
        wen.flag_we = 1'b1;
        flag_addr   = clr_idx;
        clr_next    = clr_idx + FW'(1);
      end
      S_IDLE: begin
        rd_addr  = (kind_in == KIND_REPLACE) ? hand : frame_index;
        cur_next = hand;
        if (accept) begin
          unique case (kind_in)
            KIND_INSERT, KIND_REF: begin
              if (!f_valid) begin
                res_fire   = 1'b1;
                res_status = STAT_ABSENT;
              end
            end
            KIND_REPLACE: begin
              if (count == '0) begin
                res_fire   = 1'b1;
                res_status = STAT_EMPTY;
              end
            end
            default: res_fire = 1'b1;
          endcase
        end
      end
      S_CHECK: begin
        // For an insert into a non-empty ring, fetch the link behind the hand.
        rd_addr = hand;
        if (kind_r == KIND_REF) begin
          res_fire = 1'b1;
          if (flag_q.present) begin
            wen.flag_we = 1'b1;
            flag_data   = '{present: 1'b1, referenced: 1'b1};
          end else begin
            res_status = STAT_ABSENT;
          end
        end else if (flag_q.present) begin
          res_fire   = 1'b1;
          res_status = STAT_PRESENT;
        end else if (count == '0) begin
          wen        = '{flag_we: 1'b1, next_we: 1'b1, prev_we: 1'b1, owner_we: 1'b1};
          flag_data  = '{present: 1'b1, referenced: refi_r};
          next_data  = f_r;
          prev_data  = f_r;
          hand_next  = f_r;
          count_next = count + CW'(1);
          res_fire   = 1'b1;
        end
      end
      S_HAND: begin
        wen         = '{flag_we: 1'b1, next_we: 1'b1, prev_we: 1'b1, owner_we: 1'b1};
        flag_data   = '{present: 1'b1, referenced: refi_r};
        behind_next = prev_q;
      end
      S_LINK: begin
        wen.next_we = 1'b1;
        wen.prev_we = 1'b1;
        next_addr   = behind;
        next_data   = f_r;
        prev_addr   = hand;
        prev_data   = f_r;
        count_next  = count + CW'(1);
        res_fire    = 1'b1;
      end
      S_SWEEP: begin
        wen.flag_we = 1'b1;
        flag_addr   = cur;
        if (flag_q.referenced) begin
          flag_data = '{present: 1'b1, referenced: 1'b0};
          rd_addr   = next_q;
          cur_next  = next_q;
        end else begin
          // Unlink the victim; the hand moves on unless the ring is now empty.
          wen.next_we = 1'b1;
          wen.prev_we = 1'b1;
          next_addr   = prev_q;
          next_data   = next_q;
          prev_addr   = next_q;
          prev_data   = prev_q;
          count_next  = count - CW'(1);
          if (count != CW'(1)) begin
            hand_next = next_q;
          end
          res_fire  = 1'b1;
          res_frame = cur;
          res_pid   = owner_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      hand    <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_next;
      hand    <= hand_next;
      count   <= count_next;
      done    <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    behind <= behind_next;
    if (accept) begin
      kind_r <= kind_in;
      f_r    <= frame_index;
      pid_r  <= owner_pid;
      refi_r <= ref_on_insert;
    end
    if (res_fire) begin
      status       <= res_status;
      victim_frame <= res_frame;
      victim_pid   <= res_pid;
    end
  end

endmodule

// ===== sv/cpr_store.sv =====
// Per-frame storage: flag bits, ring links and owner, one memory each.
// All four share one read address; read data is registered. Uses cpr_pkg.
module cpr_store
  import cpr_pkg::*;
#(
  parameter int FRAMES = 64,
  parameter int PROCESS_COUNT = 16,
  localparam int FW = $clog2(FRAMES),
  localparam int PW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1
) (
  input  logic          clk,
  input  logic [FW-1:0] rd_addr,
  input  wen_t          wen,
  input  logic [FW-1:0] flag_addr,
  input  flag_t         flag_data,
  input  logic [FW-1:0] next_addr,
  input  logic [FW-1:0] next_data,
  input  logic [FW-1:0] prev_addr,
  input  logic [FW-1:0] prev_data,
  input  logic [FW-1:0] owner_addr,
  input  logic [PW-1:0] owner_data,
  output flag_t         flag_q,
  output logic [FW-1:0] next_q,
  output logic [FW-1:0] prev_q,
  output logic [PW-1:0] owner_q
);

  flag_t         flag_mem  [FRAMES];
  logic [FW-1:0] next_mem  [FRAMES];
  logic [FW-1:0] prev_mem  [FRAMES];
  logic [PW-1:0] owner_mem [FRAMES];

  // The sweep clears a bit and reads the following frame in the same cycle;
  // on a ring of one frame that is the same entry, so new data is forwarded.
  always_ff @(posedge clk) begin
    if (wen.flag_we) begin
      flag_mem[flag_addr] <= flag_data;
    end
    if (wen.flag_we && (flag_addr == rd_addr)) begin
      flag_q <= flag_data;
    end else begin
      flag_q <= flag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wen.next_we) begin
      next_mem[next_addr] <= next_data;
    end
    next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.prev_we) begin
      prev_mem[prev_addr] <= prev_data;
    end
    prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.owner_we) begin
      owner_mem[owner_addr] <= owner_data;
    end
    owner_q <= owner_mem[rd_addr];
  end

endmodule

// ===== sv/cpr_checker.sv =====
// Port-level checker for the clock page replacement block, bound to the top level.
// Depends on cpr_pkg and the macros in clock_page_replacement_defines.svh.
`include "clock_page_replacement_defines.svh"

module cpr_checker
  import cpr_pkg::*;
#(
  parameter int FRAMES = 64,
  parameter int PROCESS_COUNT = 16,
  localparam int FW = $clog2(FRAMES),
  localparam int PW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic [1:0]    kind,
  input logic          done,
  input logic [1:0]    status,
  input logic [FW-1:0] victim_frame,
  input logic [PW-1:0] victim_pid
);

  // Reset starts the clearing pass, so no beat can be taken straight after it.
  `CPR_ASSERT_RST(a_reset_busy, rst |=> (busy && !done), "no clearing pass after reset")

  // An accepted item either answers at once or keeps the block busy.
  `CPR_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "accepted item lost")

  `CPR_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")

  // Only a successful replace names a victim; checked here for failed items, which leave both fields zero.
  `CPR_ASSERT(a_victim_zero, (done && status != STAT_OK) |-> (victim_frame == '0 && victim_pid == '0), "victim fields set on a failed item")

  `CPR_ASSERT(a_nop_answer, (start && !busy && kind == KIND_NOP) |=> (done && status == STAT_OK), "unknown kind not answered next cycle")

endmodule

bind clock_page_replacement cpr_checker #(
  .FRAMES        (FRAMES),
  .PROCESS_COUNT (PROCESS_COUNT)
) u_cpr_checker (.*);

// ===== verif/clock_ring_checker.sv =====
`timescale 1ns / 100ps
// Checker for the clock page replacement block: it keeps a shadow copy of the frame ring,
// predicts the outcome of every accepted command and compares it with each done beat.
// Depends on cpr_pkg for the command and status codes.
module clock_ring_checker
  import cpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] kind,
  input  logic [3:0] owner_pid,
  input  logic [5:0] frame_index,
  input  logic       ref_on_insert,
  input  logic       done,
  input  logic [1:0] status,
  input  logic [5:0] victim_frame,
  input  logic [3:0] victim_pid,
  output int         mismatch_count,
  output int         outstanding
);

  localparam int FRAMES = 64;

  typedef struct packed {
    status_t    status;
    logic [5:0] frame;
    logic [3:0] pid;
  } outcome_t;

  logic       resident   [FRAMES];
  logic       referenced [FRAMES];
  logic [3:0] owner      [FRAMES];
  logic [5:0] next_frame [FRAMES];
  logic [5:0] prev_frame [FRAMES];
  logic [5:0] hand;
  int         resident_count;
  outcome_t   awaited_outcomes [$];

  function automatic outcome_t apply_command(kind_t op, logic [3:0] pid, logic [5:0] f,
                                             logic r);
    outcome_t   res;
    logic [5:0] cur;
    logic [5:0] nx;
    logic [5:0] pv;
    logic [5:0] before_hand;
    res.status = STAT_OK;
    res.frame  = '0;
    res.pid    = '0;
    case (op)
      KIND_INSERT: begin
        if (resident[f]) begin
          res.status = STAT_PRESENT;
        end else begin
          resident[f]   = 1'b1;
          referenced[f] = r;
          owner[f]      = pid;
          if (resident_count == 0) begin
            next_frame[f] = f;
            prev_frame[f] = f;
            hand          = f;
          end else begin
            // The new frame goes just behind the hand, so the sweep reaches it last.
            before_hand             = prev_frame[hand];
            prev_frame[f]           = before_hand;
            next_frame[f]           = hand;
            next_frame[before_hand] = f;
            prev_frame[hand]        = f;
          end
          resident_count++;
        end
      end
      KIND_REF: begin
        if (!resident[f]) res.status = STAT_ABSENT;
        else referenced[f] = 1'b1;
      end
      KIND_REPLACE: begin
        if (resident_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          cur = hand;
          while (referenced[cur]) begin
            referenced[cur] = 1'b0;
            cur = next_frame[cur];
          end
          nx = next_frame[cur];
          pv = prev_frame[cur];
          next_frame[pv] = nx;
          prev_frame[nx] = pv;
          resident[cur]  = 1'b0;
          resident_count--;
          // An emptied ring leaves the hand where it was; the next insert moves it.
          if (resident_count != 0) hand = nx;
          res.frame = cur;
          res.pid   = owner[cur];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t due;
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        resident[i]   = 1'b0;
        referenced[i] = 1'b0;
      end
      hand = '0;
      resident_count = 0;
      awaited_outcomes.delete();
    end else begin
      // The result of an older command is retired before a command taken on the same edge.
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          $error("done beat with no command outstanding");
          mismatch_count++;
        end else begin
          due = awaited_outcomes.pop_front();
          if (status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status);
            mismatch_count++;
          end
          if (victim_frame !== due.frame) begin
            $error("victim_frame: expected %0d, got %0d", due.frame, victim_frame);
            mismatch_count++;
          end
          if (victim_pid !== due.pid) begin
            $error("victim_pid: expected %0d, got %0d", due.pid, victim_pid);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_outcomes.push_back(apply_command(kind_t'(kind), owner_pid, frame_index,
                                                 ref_on_insert));
      end
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the clock page replacement testbench: clock, reset, directed and random commands.
// Depends on cpr_pkg, the block clock_page_replacement and the checker clock_ring_checker.
module testbench;
  import cpr_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 80;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] kind;
  logic [3:0] owner_pid;
  logic [5:0] frame_index;
  logic       ref_on_insert;
  logic       done;
  logic [1:0] status;
  logic [5:0] victim_frame;
  logic [3:0] victim_pid;
  int         mismatch_count;
  int         outstanding;
  int         idle_cycles;
  bit         burst;

  clock_page_replacement uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .owner_pid(owner_pid),
    .frame_index(frame_index), .ref_on_insert(ref_on_insert), .done(done), .status(status),
    .victim_frame(victim_frame), .victim_pid(victim_pid)
  );

  clock_ring_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .owner_pid(owner_pid),
    .frame_index(frame_index), .ref_on_insert(ref_on_insert), .done(done), .status(status),
    .victim_frame(victim_frame), .victim_pid(victim_pid),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the command beat is taken.
  task automatic issue_command(kind_t op, logic [3:0] pid, logic [5:0] f, logic r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    kind          <= op;
    owner_pid     <= pid;
    frame_index   <= f;
    ref_on_insert <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int    mode;
    int    roll;
    int    insert_cut;
    int    ref_cut;
    int    replace_cut;
    kind_t op;
    rst           = 1'b1;
    start         = 1'b0;
    kind          = KIND_NOP;
    owner_pid     = '0;
    frame_index   = '0;
    ref_on_insert = 1'b0;
    burst         = 1'b0;
    mode          = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Empty ring, absent frames, duplicates and the full turn of the hand.
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_REF, 4'd0, 6'd5, 1'b0);
    issue_command(KIND_INSERT, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_INSERT, 4'd15, 6'd0, 1'b1);
    issue_command(KIND_REF, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_INSERT, 4'd15, 6'd63, 1'b1);
    issue_command(KIND_INSERT, 4'd3, 6'd1, 1'b1);
    issue_command(KIND_INSERT, 4'd7, 6'd2, 1'b1);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_NOP, 4'd15, 6'd63, 1'b1);
    issue_command(KIND_REF, 4'd0, 6'd2, 1'b0);
    issue_command(KIND_INSERT, 4'd9, 6'd40, 1'b0);
    issue_command(KIND_REF, 4'd0, 6'd63, 1'b0);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_REPLACE, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_NOP, 4'd0, 6'd0, 1'b0);
    issue_command(KIND_INSERT, 4'd12, 6'd33, 1'b0);
    issue_command(KIND_REF, 4'd0, 6'd34, 1'b0);

    // Phases with different mixes make the ring fill up, drain and sweep long runs of set bits.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        mode  = $urandom_range(0, 3);
        burst = ($urandom_range(0, 3) == 0);
        case (mode)
          0: begin insert_cut = 65; ref_cut = 85; replace_cut = 97; end
          1: begin insert_cut = 20; ref_cut = 40; replace_cut = 97; end
          2: begin insert_cut = 30; ref_cut = 80; replace_cut = 97; end
          default: begin insert_cut = 40; ref_cut = 65; replace_cut = 95; end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < insert_cut) op = KIND_INSERT;
      else if (roll < ref_cut) op = KIND_REF;
      else if (roll < replace_cut) op = KIND_REPLACE;
      else op = KIND_NOP;
      issue_command(op, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)));
    end
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
